### rtl/assert_macros.svh
// Assertion macros used by insertion_sort_engine, the top RTL file of the insertion sort engine.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/ise_pkg.sv
// Package of the insertion sort engine: default sizes and the cell control struct.
// Used by ise_cell and insertion_sort_engine.
package ise_pkg;

    localparam int unsigned MaxItemsDefault   = 16;
    localparam int unsigned ValueWidthDefault = 32;

    typedef struct packed {
        logic insert_en;
        logic drain_en;
    } t_cell_ctrl;

endpackage

### rtl/ise_cell.sv
// One cell of the insertion chain: holds one sorted entry and its valid bit.
// Depends on ise_pkg for the control struct.
module ise_cell
    import ise_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctrl                    i_ctrl,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_prev_valid,
    input  logic                          i_prev_greater,
    input  logic signed [VALUE_WIDTH-1:0] i_prev_value,
    input  logic                          i_next_valid,
    input  logic signed [VALUE_WIDTH-1:0] i_next_value,
    output logic                          o_valid,
    output logic                          o_greater,
    output logic signed [VALUE_WIDTH-1:0] o_value
);

    logic                          r_valid;
    logic                          n_valid;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic                          w_insert_here;

    assign o_greater     = r_valid && (r_value > i_value);
    assign w_insert_here = (!r_valid || o_greater) && i_prev_valid && !i_prev_greater;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.drain_en) begin
            n_valid = i_next_valid;
            n_value = i_next_value;
        end else if (i_ctrl.insert_en) begin
            if (i_prev_greater) begin
                n_valid = 1'b1;
                n_value = i_prev_value;
            end else if (w_insert_here) begin
                n_valid = 1'b1;
                n_value = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

### rtl/insertion_sort_engine.sv
// Insertion sort engine: a chain of MAX_ITEMS cells, one input transfer per cycle while filling.
// The transfer marked last starts a drain: results follow from the next cycle, one per cycle
// unless stalled, one for each stored entry; input is stalled until the final result moves.
// Synchronous active-low reset clears every valid bit and the overflow flag; no clearing pass.
// Depends on ise_pkg, ise_cell and assert_macros.svh.
`include "assert_macros.svh"
module insertion_sort_engine
    import ise_pkg::*;
#(
    parameter int unsigned MAX_ITEMS   = MaxItemsDefault,
    parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_sorted_value,
    output logic                          o_run_end,
    output logic                          o_overflow
);

    logic                          r_drain;
    logic                          n_drain;
    logic                          r_flag;
    logic                          n_flag;
    logic                          w_in_xfer;
    logic                          w_full;
    t_cell_ctrl                    w_ctrl;
    logic [MAX_ITEMS-1:0]          w_valid;
    logic [MAX_ITEMS-1:0]          w_greater;
    logic signed [VALUE_WIDTH-1:0] w_cell_value [MAX_ITEMS];

    assign w_full           = w_valid[MAX_ITEMS-1];
    assign w_in_xfer        = i_valid && !o_stall;
    assign w_ctrl.insert_en = w_in_xfer && !w_full;
    assign w_ctrl.drain_en  = o_valid && !i_stall;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic                          w_prev_valid;
        logic                          w_prev_greater;
        logic signed [VALUE_WIDTH-1:0] w_prev_value;
        logic                          w_next_valid;
        logic signed [VALUE_WIDTH-1:0] w_next_value;

        if (g == 0) begin : g_first
            assign w_prev_valid   = 1'b1;
            assign w_prev_greater = 1'b0;
            assign w_prev_value   = i_value;
        end else begin : g_inner
            assign w_prev_valid   = w_valid[g-1];
            assign w_prev_greater = w_greater[g-1];
            assign w_prev_value   = w_cell_value[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_top
            assign w_next_valid = 1'b0;
            assign w_next_value = w_cell_value[g];
        end else begin : g_below
            assign w_next_valid = w_valid[g+1];
            assign w_next_value = w_cell_value[g+1];
        end

        ise_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_value       (i_value),
            .i_prev_valid  (w_prev_valid),
            .i_prev_greater(w_prev_greater),
            .i_prev_value  (w_prev_value),
            .i_next_valid  (w_next_valid),
            .i_next_value  (w_next_value),
            .o_valid       (w_valid[g]),
            .o_greater     (w_greater[g]),
            .o_value       (w_cell_value[g])
        );
    end

    always_comb begin
        n_drain = r_drain;
        n_flag  = r_flag;
        if (w_ctrl.drain_en && !w_valid[1]) begin
            n_drain = 1'b0;
            n_flag  = 1'b0;
        end else if (w_in_xfer) begin
            if (w_full) begin
                n_flag = 1'b1;
            end
            if (i_last) begin
                n_drain = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_flag  <= 1'b0;
        end else begin
            r_drain <= n_drain;
            r_flag  <= n_flag;
        end
    end

    assign o_stall        = r_drain;
    assign o_valid        = r_drain && w_valid[0];
    assign o_sorted_value = w_cell_value[0];
    assign o_run_end      = !w_valid[1];
    assign o_overflow     = r_flag;

    `ASSERT_RST(a_valid_packed, i_clk, i_rst_n, (w_valid & (w_valid + 1'b1)) == '0, "Valid cells are not contiguous from the bottom.")
    `ASSERT_RST(a_last_starts_run, i_clk, i_rst_n, w_in_xfer && i_last |=> o_valid, "No result follows the last input transfer.")
    `ASSERT_RST(a_run_continues, i_clk, i_rst_n, o_valid && !i_stall && !o_run_end |=> o_valid, "Sorted run stopped before its end.")
    `ASSERT_RST(a_run_stops, i_clk, i_rst_n, o_valid && !i_stall && o_run_end |=> !o_valid && !o_overflow, "Results continue after the end of the run.")
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall, "Block is not idle after reset.")

endmodule
